// ===== sv/assert_macros.svh =====
// Assertion macros shared by the order book price level RTL.
// Used by the top level; relies on a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OBPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OBPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/obpl_pkg.sv =====
// Package for the order book price level unit: field widths, the per-request
// operation code and the control and status bundles passed between modules.
`timescale 1ns / 1ps

package obpl_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 31;
  localparam int unsigned WIDE_W  = 33;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_DELETE,
    OP_INSERT
  } obpl_op_t;

  typedef struct packed {
    logic               cmp_en;
    logic               apply_en;
    obpl_op_t           op;
    logic [PRICE_W-1:0] key_price;
    logic [QTY_W-1:0]   key_qty;
  } obpl_ctrl_t;

  typedef struct packed {
    logic               hit;
    logic               full;
    logic               head_valid;
    logic [PRICE_W-1:0] head_price;
  } obpl_stat_t;

endpackage

// ===== sv/obpl_if.sv =====
// Valid/ready channel interfaces for the order book price level unit.
// Depends on obpl_pkg for the field widths.
`timescale 1ns / 1ps

interface obpl_in_if import obpl_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [PRICE_W-1:0] price_ticks;
  logic [QTY_W-1:0]   level_quantity;

  modport source (output valid, action, price_ticks, level_quantity, input ready);
  modport sink   (input valid, action, price_ticks, level_quantity, output ready);
endinterface

interface obpl_out_if import obpl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [PRICE_W-1:0]        high_bid;
  logic [PRICE_W-1:0]        low_ask;
  logic signed [WIDE_W-1:0]  spread;
  logic [WIDE_W-1:0]         mid_twice;
  logic                      table_full;

  modport source (output valid, high_bid, low_ask, spread, mid_twice, table_full,
                  input ready);
  modport sink   (input valid, high_bid, low_ask, spread, mid_twice, table_full,
                  output ready);
endinterface

// ===== sv/obpl_cell.sv =====
// One price level slot of a sorted row: holds price, quantity and a valid bit.
// Depends on obpl_pkg; the row keeps prices in strictly descending order.
`timescale 1ns / 1ps

module obpl_cell import obpl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  obpl_ctrl_t         ctrl,
  input  logic               left_ahead,
  input  logic               left_valid,
  input  logic [PRICE_W-1:0] left_price,
  input  logic [QTY_W-1:0]   left_qty,
  input  logic               right_valid,
  input  logic [PRICE_W-1:0] right_price,
  input  logic [QTY_W-1:0]   right_qty,
  output logic               ahead,
  output logic               match,
  output logic               valid,
  output logic [PRICE_W-1:0] price,
  output logic [QTY_W-1:0]   qty,
  output logic               valid_next,
  output logic [PRICE_W-1:0] price_next
);

  logic             ahead_cmp;
  logic             match_cmp;
  logic [QTY_W-1:0] qty_next;

  assign ahead_cmp = valid && (price > ctrl.key_price);
  assign match_cmp = valid && (price == ctrl.key_price);

  always_comb begin
    valid_next = valid;
    price_next = price;
    qty_next   = qty;
    if (ctrl.apply_en) begin
      unique case (ctrl.op)
        OP_UPDATE: begin
          if (match) begin
            qty_next = ctrl.key_qty;
          end
        end
        OP_DELETE: begin
          // Every slot from the removed level onwards moves one place up.
          if (!ahead) begin
            valid_next = right_valid;
            price_next = right_price;
            qty_next   = right_qty;
          end
        end
        OP_INSERT: begin
          if (!ahead) begin
            if (left_ahead) begin
              valid_next = 1'b1;
              price_next = ctrl.key_price;
              qty_next   = ctrl.key_qty;
            end else begin
              valid_next = left_valid;
              price_next = left_price;
              qty_next   = left_qty;
            end
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ahead <= 1'b0;
      match <= 1'b0;
    end else begin
      valid <= valid_next;
      if (ctrl.cmp_en) begin
        ahead <= ahead_cmp;
        match <= match_cmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    price <= price_next;
    qty   <= qty_next;
  end

endmodule

// ===== sv/obpl_chain.sv =====
// A row of LEVELS price level cells forming one side of the book.
// Depends on obpl_pkg and obpl_cell; the head cell always holds the best level.
`timescale 1ns / 1ps

module obpl_chain import obpl_pkg::*; #(
  parameter int unsigned LEVELS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  obpl_ctrl_t ctrl,
  output obpl_stat_t stat
);

  logic [LEVELS-1:0]  ahead_v;
  logic [LEVELS-1:0]  match_v;
  logic [LEVELS-1:0]  valid_v;
  logic [PRICE_W-1:0] price_v [LEVELS];
  logic [QTY_W-1:0]   qty_v   [LEVELS];
  logic [LEVELS-1:0]  valid_nx_v;
  logic [PRICE_W-1:0] price_nx_v [LEVELS];

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic               l_ahead;
    logic               l_valid;
    logic [PRICE_W-1:0] l_price;
    logic [QTY_W-1:0]   l_qty;
    logic               r_valid;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;

    if (i == 0) begin : g_head
      assign l_ahead = 1'b1;
      assign l_valid = 1'b0;
      assign l_price = '0;
      assign l_qty   = '0;
    end else begin : g_body
      assign l_ahead = ahead_v[i-1];
      assign l_valid = valid_v[i-1];
      assign l_price = price_v[i-1];
      assign l_qty   = qty_v[i-1];
    end

    if (i == LEVELS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_price = '0;
      assign r_qty   = '0;
    end else begin : g_inner
      assign r_valid = valid_v[i+1];
      assign r_price = price_v[i+1];
      assign r_qty   = qty_v[i+1];
    end

    obpl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_ahead (l_ahead),
      .left_valid (l_valid),
      .left_price (l_price),
      .left_qty   (l_qty),
      .right_valid(r_valid),
      .right_price(r_price),
      .right_qty  (r_qty),
      .ahead      (ahead_v[i]),
      .match      (match_v[i]),
      .valid      (valid_v[i]),
      .price      (price_v[i]),
      .qty        (qty_v[i]),
      .valid_next (valid_nx_v[i]),
      .price_next (price_nx_v[i])
    );
  end

  assign stat.hit        = |match_v;
  assign stat.full       = valid_v[LEVELS-1];
  assign stat.head_valid = valid_nx_v[0];
  assign stat.head_price = price_nx_v[0];

endmodule

// ===== sv/order_book_price_levels_unit.sv =====
// A request is held in the request register, compared by the cell rows in the
// compare state and applied in the apply state, which loads the result register;
// the update waits while the result register is still full. A new request is
// accepted only when idle or as the previous update is applied, not during compare.
// Reset (synchronous, active high) clears every cell valid bit, the sequencer
// and the result valid flag. Depends on obpl_pkg, obpl_if.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module order_book_price_levels_unit import obpl_pkg::*; #(
  parameter int unsigned LEVELS = 64
) (
  input  logic              clk,
  input  logic              rst,
  obpl_in_if.sink           req,
  obpl_out_if.source        rsp
);

  // The sequencer walks each request through a compare cycle, in which every
  // cell of both rows compares its price with the request price, and an apply
  // cycle, in which the chosen row shifts or updates in a single step.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  state_t             state;
  logic               req_side;
  logic [PRICE_W-1:0] req_price;
  logic [QTY_W-1:0]   req_qty;
  logic               out_valid;
  logic [PRICE_W-1:0] high_bid;
  logic [PRICE_W-1:0] low_ask;
  logic               table_full;

  obpl_ctrl_t bid_ctrl;
  obpl_ctrl_t ask_ctrl;
  obpl_stat_t bid_stat;
  obpl_stat_t ask_stat;
  obpl_stat_t act_stat;
  obpl_op_t   op;
  logic       qty_zero;
  logic       dropped;
  logic       apply_fire;
  logic       req_fire;

  // The update is applied only when the result register can take the result.
  assign apply_fire = (state == ST_APPLY) && (!out_valid || rsp.ready);
  assign req.ready  = (state == ST_IDLE) || apply_fire;
  assign req_fire   = req.valid && req.ready;

  // Decide what the addressed side does with the request, from the flags the
  // cells registered during the compare cycle.
  assign act_stat = req_side ? ask_stat : bid_stat;
  assign qty_zero = (req_qty == '0);

  always_comb begin
    priority if (act_stat.hit) begin
      op = qty_zero ? OP_DELETE : OP_UPDATE;
    end else if (qty_zero || act_stat.full) begin
      op = OP_NONE;
    end else begin
      op = OP_INSERT;
    end
  end

  assign dropped = !act_stat.hit && !qty_zero && act_stat.full;

  // Bids are held highest first. Asks are held as inverted prices, so that the
  // same descending row keeps the lowest ask at its head.
  assign bid_ctrl.cmp_en    = (state == ST_CMP);
  assign bid_ctrl.apply_en  = apply_fire && !req_side;
  assign bid_ctrl.op        = op;
  assign bid_ctrl.key_price = req_price;
  assign bid_ctrl.key_qty   = req_qty;

  assign ask_ctrl.cmp_en    = (state == ST_CMP);
  assign ask_ctrl.apply_en  = apply_fire && req_side;
  assign ask_ctrl.op        = op;
  assign ask_ctrl.key_price = ~req_price;
  assign ask_ctrl.key_qty   = req_qty;

  obpl_chain #(.LEVELS(LEVELS)) u_bid_chain (
    .clk (clk),
    .rst (rst),
    .ctrl(bid_ctrl),
    .stat(bid_stat)
  );

  obpl_chain #(.LEVELS(LEVELS)) u_ask_chain (
    .clk (clk),
    .rst (rst),
    .ctrl(ask_ctrl),
    .stat(ask_stat)
  );

  // Sequencer, request register and result register. The best prices are
  // taken from the head cells' next values, so they already reflect the update
  // applied in the same cycle. An empty side reports zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (apply_fire) begin
            state <= req_fire ? ST_CMP : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (apply_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end

    if (req_fire) begin
      req_side  <= req.action;
      req_price <= req.price_ticks;
      req_qty   <= req.level_quantity;
    end

    if (apply_fire) begin
      high_bid   <= bid_stat.head_valid ? bid_stat.head_price : '0;
      low_ask    <= ask_stat.head_valid ? ~ask_stat.head_price : '0;
      table_full <= dropped;
    end
  end

  // Spread and doubled mid price follow directly from the registered bests.
  assign rsp.valid      = out_valid;
  assign rsp.high_bid   = high_bid;
  assign rsp.low_ask    = low_ask;
  assign rsp.spread     = signed'({1'b0, low_ask} - {1'b0, high_bid});
  assign rsp.mid_twice  = {1'b0, high_bid} + {1'b0, low_ask};
  assign rsp.table_full = table_full;

  // A request is always followed by a compare cycle.
  `OBPL_ASSERT_NXT(a_req_then_cmp, req_fire, state == ST_CMP, "request not compared")
  // Each applied update leaves a result waiting.
  `OBPL_ASSERT_NXT(a_apply_gives_result, apply_fire, out_valid, "result lost")
  // A dropped insert only happens on a full side holding no such price.
  `OBPL_ASSERT_IMP(a_drop_only_full, apply_fire && dropped,
                   act_stat.full && !act_stat.hit && op == OP_NONE, "bad drop")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for order_book_price_levels_unit: drives level requests,
// predicts the top-of-book quote for each one and checks every returned quote.
// Depends on obpl_pkg and the obpl_in_if / obpl_out_if channel interfaces.
`timescale 1ns / 1ps

module tb import obpl_pkg::*;;

  localparam int unsigned BOOK_LEVELS = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_REQUESTS = 950;
  localparam bit SIDE_BID = 1'b0;
  localparam bit SIDE_ASK = 1'b1;
  localparam logic [QTY_W-1:0] QTY_REMOVE = '0;
  localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
  localparam logic [QTY_W-1:0] QTY_TOP = '1;

  typedef struct packed {
    logic [PRICE_W-1:0]       high_bid;
    logic [PRICE_W-1:0]       low_ask;
    logic signed [WIDE_W-1:0] spread;
    logic [WIDE_W-1:0]        mid_twice;
    logic                     table_full;
  } quote_t;

  // Shadow copy of both price-level tables plus the quotes still owed by the block.
  class top_of_book_scoreboard;
    logic [PRICE_W-1:0] level_price [2][BOOK_LEVELS];
    logic [QTY_W-1:0]   level_qty [2][BOOK_LEVELS];
    bit                 level_live [2][BOOK_LEVELS];
    quote_t             quotes_due [$];
    int unsigned        errors;

    function new();
      errors = 0;
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < BOOK_LEVELS; i++)
          level_live[s][i] = 1'b0;
    endfunction

    // Applies one level change to a side; returns 1 when an insert found no room.
    function bit apply_level(bit side, logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
      int free_slot;
      free_slot = -1;
      for (int slot = 0; slot < BOOK_LEVELS; slot++) begin
        if (level_live[side][slot] && level_price[side][slot] == price) begin
          if (qty == QTY_REMOVE) level_live[side][slot] = 1'b0;
          else level_qty[side][slot] = qty;
          return 1'b0;
        end
        if (!level_live[side][slot] && free_slot < 0) free_slot = slot;
      end
      if (qty == QTY_REMOVE) return 1'b0;
      if (free_slot < 0) return 1'b1;
      level_price[side][free_slot] = price;
      level_qty[side][free_slot]   = qty;
      level_live[side][free_slot]  = 1'b1;
      return 1'b0;
    endfunction

    // Highest live bid or lowest live ask; an empty side gives zero.
    function logic [PRICE_W-1:0] best_price(bit side);
      logic [PRICE_W-1:0] best;
      bit found;
      best  = '0;
      found = 1'b0;
      for (int slot = 0; slot < BOOK_LEVELS; slot++) begin
        if (level_live[side][slot]) begin
          if (!found || (side == SIDE_BID ? level_price[side][slot] > best
                                          : level_price[side][slot] < best)) begin
            best  = level_price[side][slot];
            found = 1'b1;
          end
        end
      end
      return best;
    endfunction

    function void note_request(bit side, logic [PRICE_W-1:0] price,
                               logic [QTY_W-1:0] qty);
      quote_t q;
      q.table_full = apply_level(side, price, qty);
      q.high_bid   = best_price(SIDE_BID);
      q.low_ask    = best_price(SIDE_ASK);
      q.spread     = {1'b0, q.low_ask} - {1'b0, q.high_bid};
      q.mid_twice  = {1'b0, q.low_ask} + {1'b0, q.high_bid};
      quotes_due.push_back(q);
    endfunction

    function void check_result(logic [PRICE_W-1:0] bid, logic [PRICE_W-1:0] ask,
                               logic signed [WIDE_W-1:0] spread,
                               logic [WIDE_W-1:0] mid, logic full);
      quote_t q;
      if (quotes_due.size() == 0) begin
        $error("quote returned with no request outstanding");
        errors++;
        return;
      end
      q = quotes_due.pop_front();
      if (bid !== q.high_bid) begin
        $error("high_bid: expected %0d, got %0d", q.high_bid, bid);
        errors++;
      end
      if (ask !== q.low_ask) begin
        $error("low_ask: expected %0d, got %0d", q.low_ask, ask);
        errors++;
      end
      if (spread !== q.spread) begin
        $error("spread: expected %0d, got %0d", q.spread, spread);
        errors++;
      end
      if (mid !== q.mid_twice) begin
        $error("mid_twice: expected %0d, got %0d", q.mid_twice, mid);
        errors++;
      end
      if (full !== q.table_full) begin
        $error("table_full: expected %0b, got %0b", q.table_full, full);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return quotes_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  obpl_in_if  req ();
  obpl_out_if rsp ();

  order_book_price_levels_unit #(.LEVELS(BOOK_LEVELS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  top_of_book_scoreboard book = new();
  int unsigned burst_left = 0;
  int unsigned levels_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  logic [31:0] stall_pattern = '1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver replays a rotating stall pattern that is reloaded now and then;
  // an all-ones pattern gives stretches with no back-pressure at all.
  always @(posedge clk) begin
    if (hold_cycles == 0) begin
      hold_cycles <= $urandom_range(16, 96);
      case ($urandom_range(0, 2))
        0: stall_pattern <= '1;
        1: stall_pattern <= $urandom;
        default: stall_pattern <= $urandom & $urandom;
      endcase
    end else begin
      hold_cycles   <= hold_cycles - 1;
      stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
    end
    rsp.ready <= stall_pattern[0];
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      book.check_result(rsp.high_bid, rsp.low_ask, rsp.spread, rsp.mid_twice,
                        rsp.table_full);
  end

  function automatic logic [QTY_W-1:0] random_quantity();
    case ($urandom_range(0, 7))
      0: return QTY_TOP;
      1: return QTY_W'(1);
      2: return QTY_W'($urandom_range(1, 100));
      default: return QTY_W'($urandom);
    endcase
  endfunction

  // Offers one request; the sender goes quiet for a while at the end of each burst.
  task automatic send_level(input bit side, input logic [PRICE_W-1:0] price,
                            input logic [QTY_W-1:0] qty);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    req.valid          <= 1'b1;
    req.action         <= side;
    req.price_ticks    <= price;
    req.level_quantity <= qty;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    book.note_request(side, price, qty);
    burst_left--;
    levels_sent++;
  endtask

  // Holds the sender off until every owed quote has come back.
  task automatic wait_quiet();
    req.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  initial begin
    int unsigned stop_at;
    int unsigned run_len;
    int unsigned stride;
    int unsigned pick;
    bit side;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] victims [$];

    rst                <= 1'b1;
    req.valid          <= 1'b0;
    req.action         <= SIDE_BID;
    req.price_ticks    <= '0;
    req.level_quantity <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero-priced levels, range extremes, a crossed book and
    // deletes of prices that are not in the book.
    send_level(SIDE_BID, 0, 5);
    send_level(SIDE_ASK, 7, QTY_REMOVE);
    send_level(SIDE_ASK, PRICE_TOP, QTY_TOP);
    send_level(SIDE_BID, PRICE_TOP, 1);
    send_level(SIDE_ASK, 100, 1);
    send_level(SIDE_ASK, 100, 77);
    send_level(SIDE_BID, PRICE_TOP, QTY_REMOVE);
    send_level(SIDE_BID, 0, QTY_REMOVE);
    send_level(SIDE_BID, 55, QTY_REMOVE);
    send_level(SIDE_ASK, 100, QTY_REMOVE);
    send_level(SIDE_BID, 1000, 3);
    send_level(SIDE_ASK, 1005, 4);
    send_level(SIDE_BID, 32'h8000_0000, 31'h4000_0000);
    send_level(SIDE_ASK, 0, 9);
    send_level(SIDE_ASK, 0, 31'h2AAA_AAAA);
    send_level(SIDE_BID, 32'hAAAA_AAAA, 31'h5555_5555);
    send_level(SIDE_ASK, 32'h5555_5555, 31'h2AAA_AAAA);
    send_level(SIDE_ASK, 0, QTY_REMOVE);
    send_level(SIDE_BID, 32'h8000_0000, QTY_REMOVE);
    send_level(SIDE_ASK, PRICE_TOP, QTY_REMOVE);
    wait_quiet();

    // Random part, in phases: churn on a narrow price band, filling a side past
    // capacity, draining a side level by level, and unstructured noise.
    stop_at = levels_sent + RANDOM_REQUESTS;
    while (levels_sent < stop_at) begin
      side = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          case ($urandom_range(0, 9))
            0: base = '0;
            1: base = 32'hFFFF_FFF0;
            default: base = $urandom;
          endcase
          run_len = $urandom_range(20, 60);
          repeat (run_len)
            send_level(1'($urandom_range(0, 1)), base + $urandom_range(0, 15),
                       ($urandom_range(0, 2) == 0) ? QTY_REMOVE : random_quantity());
        end
        4, 5: begin
          // Distinct prices overflow the side; then a hit and a miss while full.
          base   = $urandom;
          stride = $urandom_range(1, 1000);
          for (int i = 0; i < BOOK_LEVELS + 8; i++)
            send_level(side, base + i * stride, random_quantity());
          send_level(side, base, random_quantity());
          send_level(side, base - 1, QTY_REMOVE);
        end
        6, 7: begin
          victims.delete();
          for (int i = 0; i < BOOK_LEVELS; i++)
            if (book.level_live[side][i]) victims.push_back(book.level_price[side][i]);
          while (victims.size() != 0) begin
            pick = $urandom_range(0, victims.size() - 1);
            send_level(side, victims[pick], QTY_REMOVE);
            victims.delete(pick);
            if ($urandom_range(0, 7) == 0)
              send_level(!side, $urandom, random_quantity());
          end
        end
        default: begin
          run_len = $urandom_range(10, 30);
          repeat (run_len)
            send_level(1'($urandom_range(0, 1)), $urandom,
                       ($urandom_range(0, 3) == 0) ? QTY_REMOVE : random_quantity());
        end
      endcase
      if ($urandom_range(0, 3) == 0) wait_quiet();
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/obpl_pkg.sv
sv/obpl_if.sv
sv/obpl_cell.sv
sv/obpl_chain.sv
sv/order_book_price_levels_unit.sv
dv/tb.sv
